[hdl/rhps_pkg.sv]
// -----------------------------------------------------------------------------
// RGB histogram peak scaler package
// Sizes, command and register codes, shared types and small helper functions.
// -----------------------------------------------------------------------------
package rhps_pkg;

  localparam int BIN_NUMBER     = 256;
  localparam int COUNT_BITS     = 24;
  localparam int CHANNEL_NUMBER = 3;

  localparam int SAMPLE_BITS   = 8;
  localparam int CHAN_BITS     = 2;
  localparam int CMD_BITS      = 2;
  localparam int OUT_BITS      = 24;
  localparam int BAR_BITS      = 10;
  localparam int BIN_BITS      = $clog2(BIN_NUMBER);
  localparam int PROD_BITS     = COUNT_BITS + BAR_BITS;
  localparam int STEP_BITS     = $clog2(BAR_BITS);
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 10;

  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [BIN_BITS-1:0]    bin_t;
  typedef logic [BAR_BITS-1:0]    bar_t;
  typedef logic [OUT_BITS-1:0]    out_t;
  typedef logic [PROD_BITS-1:0]   prod_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [STEP_BITS-1:0]   step_t;

  localparam count_t COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam out_t   OUT_MAX     = {OUT_BITS{1'b1}};
  localparam bar_t   SCALE_RESET = bar_t'(125);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_COUNT = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SINGLE_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAR_SCALE      = 1'd1;

  typedef struct packed {
    logic   start;
    count_t count;
    count_t peak;
    bar_t   scale;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic valid;
    bar_t quotient;
  } div_stat_t;

  // Samples beyond the last bin land in the last bin.
  function automatic bin_t bin_of(sample_t s);
    if ({1'b0, s} >= (SAMPLE_BITS + 1)'(BIN_NUMBER)) begin
      return bin_t'(BIN_NUMBER - 1);
    end
    return bin_t'(s);
  endfunction

  function automatic out_t clip_out(count_t v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > 33'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return out_t'(v);
  endfunction

endpackage

[hdl/rhps_in_if.sv]
// -----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one pixel, query or clear command.
// -----------------------------------------------------------------------------
interface rhps_in_if;
  logic                                valid;
  logic                                ready;
  logic [rhps_pkg::CMD_BITS-1:0]       command;
  logic [rhps_pkg::SAMPLE_BITS-1:0]    sample_blue;
  logic [rhps_pkg::SAMPLE_BITS-1:0]    sample_green;
  logic [rhps_pkg::SAMPLE_BITS-1:0]    sample_red;
  logic [rhps_pkg::CHAN_BITS-1:0]      query_channel;
  logic [rhps_pkg::SAMPLE_BITS-1:0]    query_bin;

  modport source (
    output valid, command, sample_blue, sample_green, sample_red, query_channel,
           query_bin,
    input  ready
  );

  modport sink (
    input  valid, command, sample_blue, sample_green, sample_red, query_channel,
           query_bin,
    output ready
  );
endinterface

[hdl/rhps_out_if.sv]
// -----------------------------------------------------------------------------
// Query result channel
// Valid/ready channel that carries one bin count, peak and bar height.
// -----------------------------------------------------------------------------
interface rhps_out_if;
  logic                          valid;
  logic                          ready;
  logic [rhps_pkg::OUT_BITS-1:0] bin_count;
  logic [rhps_pkg::OUT_BITS-1:0] peak_count;
  logic [rhps_pkg::BAR_BITS-1:0] bar_height;

  modport source (
    output valid, bin_count, peak_count, bar_height,
    input  ready
  );

  modport sink (
    input  valid, bin_count, peak_count, bar_height,
    output ready
  );
endinterface

[hdl/rhps_ram.sv]
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
module rhps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rhps_bar_div.sv]
// -----------------------------------------------------------------------------
// Bar height unit
// Multiplies count by scale, then divides by the peak one quotient bit a cycle.
// -----------------------------------------------------------------------------
module rhps_bar_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rhps_pkg::div_req_t  req,
  input  logic                ack,
  output rhps_pkg::div_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t           state_r;
  rhps_pkg::count_t count_r;
  rhps_pkg::count_t peak_r;
  rhps_pkg::bar_t   scale_r;
  logic             peak_zero_r;
  rhps_pkg::prod_t  rem_r;
  rhps_pkg::prod_t  den_r;
  rhps_pkg::bar_t   quot_r;
  rhps_pkg::step_t  step_r;

  logic             fits;
  rhps_pkg::prod_t  rem_sub;

  assign fits    = (rem_r >= den_r);
  assign rem_sub = rem_r - den_r;

  // The bin count never exceeds its channel peak, so the quotient never exceeds
  // the scale and BAR_BITS quotient bits are enough.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            count_r     <= req.count;
            peak_r      <= req.peak;
            scale_r     <= req.scale;
            peak_zero_r <= (req.peak == '0);
            state_r     <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem_r   <= rhps_pkg::prod_t'(count_r) * rhps_pkg::prod_t'(scale_r);
          den_r   <= rhps_pkg::prod_t'(peak_r) << (rhps_pkg::BAR_BITS - 1);
          quot_r  <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (fits) begin
            rem_r <= rem_sub;
          end
          quot_r <= {quot_r[rhps_pkg::BAR_BITS-2:0], fits};
          den_r  <= den_r >> 1;
          if (step_r == rhps_pkg::step_t'(rhps_pkg::BAR_BITS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.busy     = (state_r != ST_IDLE);
  assign stat.valid    = (state_r == ST_DONE);
  assign stat.quotient = peak_zero_r ? '0 : quot_r;

endmodule

[hdl/rgb_histogram_peak_scaler.sv]
// -----------------------------------------------------------------------------
// RGB histogram peak scaler
// Per-channel 256-bin histograms with running peaks and bar height queries.
// -----------------------------------------------------------------------------
// Commands arrive on in_chan with a valid/ready handshake. A pixel command adds
// one to the selected bin of each counted channel (three colors, or only the
// gray sample when single_channel is set); counts saturate. A query returns one
// transfer on out_chan with the bin count, the channel peak and the bar height
// count * bar_scale / peak. A clear command zeroes all bins and peaks.
// Each channel's bins sit in their own RAM with registered read data. Pixels
// go through a read-modify-write with forwarding and are taken one per cycle
// while no clear, query or busy divider holds in_chan off. A query holds
// in_chan off through the bin read, the multiply, the restoring divider and
// the handover to the output register, after which its result is valid on
// out_chan. A clear holds in_chan off while it zeroes one RAM row per cycle.
// After reset the same clearing pass runs before ready rises; configuration
// writes on cfg_* are taken at any time. A stalled result waits in the output
// register; pixel commands keep being taken meanwhile. A further query is
// taken, but its result waits in the divider and in_chan stays closed until
// the earlier result has left.
// -----------------------------------------------------------------------------
module rgb_histogram_peak_scaler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rhps_in_if.sink                              in_chan,
  rhps_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [rhps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rhps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int CH = rhps_pkg::CHANNEL_NUMBER;

  logic                   single_channel_r;
  rhps_pkg::bar_t         bar_scale_r;

  logic                   in_xfer;
  rhps_pkg::cmd_t         in_cmd;

  logic                   clr_busy_r;
  rhps_pkg::bin_t         clr_addr_r;

  logic                   s1_valid_r;
  rhps_pkg::cmd_t         s1_cmd_r;
  logic [rhps_pkg::CHAN_BITS-1:0] s1_qchan_r;
  logic [CH-1:0]          s1_en_r;
  rhps_pkg::bin_t         s1_bin_r [CH];
  logic [CH-1:0]          fwd_r;
  rhps_pkg::count_t       fwd_data_r [CH];
  rhps_pkg::count_t       peak_r [CH];

  logic                   s1_count;
  logic                   s1_query;
  logic                   s1_clear;
  logic [CH-1:0]          s1_wr;
  rhps_pkg::bin_t         rd_addr [CH];
  rhps_pkg::count_t       rd_data [CH];
  rhps_pkg::count_t       cur [CH];
  rhps_pkg::count_t       inc [CH];

  rhps_pkg::count_t       q_count;
  rhps_pkg::count_t       q_peak;
  rhps_pkg::count_t       q_count_r;
  rhps_pkg::count_t       q_peak_r;

  rhps_pkg::div_req_t     div_req;
  rhps_pkg::div_stat_t    div_stat;
  logic                   div_ack;

  logic                   out_valid_r;
  rhps_pkg::out_t         out_bin_count_r;
  rhps_pkg::out_t         out_peak_count_r;
  rhps_pkg::bar_t         out_bar_height_r;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign in_cmd   = rhps_pkg::cmd_t'(in_chan.command);
  assign s1_count = s1_valid_r && (s1_cmd_r == rhps_pkg::CMD_COUNT);
  assign s1_query = s1_valid_r && (s1_cmd_r == rhps_pkg::CMD_QUERY);
  assign s1_clear = s1_valid_r && (s1_cmd_r == rhps_pkg::CMD_CLEAR);

  assign in_chan.ready = !clr_busy_r && !s1_query && !s1_clear && !div_stat.busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_channel_r <= 1'b0;
      bar_scale_r      <= rhps_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rhps_pkg::CFG_SINGLE_CHANNEL: single_channel_r <= cfg_wdata[0];
        rhps_pkg::CFG_BAR_SCALE:      bar_scale_r      <= cfg_wdata[rhps_pkg::BAR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clearing pass over all RAM rows, after reset and after a clear command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (s1_clear) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == rhps_pkg::bin_t'(rhps_pkg::BIN_NUMBER - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r   <= in_cmd;
      s1_qchan_r <= in_chan.query_channel;
    end
  end

  for (genvar c = 0; c < CH; c++) begin : g_chan
    rhps_pkg::sample_t samp;
    logic              has_samp;
    logic              wr_en;
    rhps_pkg::bin_t    wr_addr;
    rhps_pkg::count_t  wr_data;

    if (c == 0) begin : g_blue
      assign samp     = in_chan.sample_blue;
      assign has_samp = 1'b1;
    end else if (c == 1) begin : g_green
      assign samp     = in_chan.sample_green;
      assign has_samp = 1'b1;
    end else if (c == 2) begin : g_red
      assign samp     = in_chan.sample_red;
      assign has_samp = 1'b1;
    end else begin : g_none
      assign samp     = '0;
      assign has_samp = 1'b0;
    end

    assign rd_addr[c] = (in_cmd == rhps_pkg::CMD_QUERY) ?
                        rhps_pkg::bin_of(in_chan.query_bin) : rhps_pkg::bin_of(samp);

    // A pixel one transfer ahead writes back in the same cycle as this read,
    // so its new count is forwarded instead of the stale RAM word.
    assign cur[c] = fwd_r[c] ? fwd_data_r[c] : rd_data[c];
    assign inc[c] = (cur[c] == rhps_pkg::COUNT_MAX) ? cur[c] :
                    cur[c] + rhps_pkg::count_t'(1);
    assign s1_wr[c] = s1_count && s1_en_r[c];

    assign wr_en   = clr_busy_r || s1_wr[c];
    assign wr_addr = clr_busy_r ? clr_addr_r : s1_bin_r[c];
    assign wr_data = clr_busy_r ? '0 : inc[c];

    rhps_ram #(
      .WIDTH (rhps_pkg::COUNT_BITS),
      .DEPTH (rhps_pkg::BIN_NUMBER)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (in_xfer),
      .raddr (rd_addr[c]),
      .rdata (rd_data[c])
    );

    always_ff @(posedge clk) begin
      if (in_xfer) begin
        s1_bin_r[c]   <= rd_addr[c];
        s1_en_r[c]    <= has_samp && ((c == 0) || !single_channel_r);
        fwd_r[c]      <= s1_wr[c] && (s1_bin_r[c] == rd_addr[c]);
        fwd_data_r[c] <= inc[c];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        peak_r[c] <= '0;
      end else if (s1_clear) begin
        peak_r[c] <= '0;
      end else if (s1_wr[c] && (inc[c] > peak_r[c])) begin
        peak_r[c] <= inc[c];
      end
    end
  end

  // Channels without a histogram answer with zeros.
  always_comb begin
    q_count = '0;
    q_peak  = '0;
    for (int c = 0; c < CH; c++) begin
      if (s1_qchan_r == rhps_pkg::CHAN_BITS'(c)) begin
        q_count = cur[c];
        q_peak  = peak_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_query) begin
      q_count_r <= q_count;
      q_peak_r  <= q_peak;
    end
  end

  assign div_req.start = s1_query;
  assign div_req.count = q_count;
  assign div_req.peak  = q_peak;
  assign div_req.scale = bar_scale_r;
  assign div_ack       = div_stat.valid && (!out_valid_r || out_chan.ready);

  rhps_bar_div u_bar_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .ack   (div_ack),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ack) begin
      out_bin_count_r  <= rhps_pkg::clip_out(q_count_r);
      out_peak_count_r <= rhps_pkg::clip_out(q_peak_r);
      out_bar_height_r <= div_stat.quotient;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.bin_count  = out_bin_count_r;
  assign out_chan.peak_count = out_peak_count_r;
  assign out_chan.bar_height = out_bar_height_r;

endmodule

[hdl/rhps_checker.sv]
// -----------------------------------------------------------------------------
// RGB histogram peak scaler checker
// Port-level assertions, attached to the top level by a bind statement.
// -----------------------------------------------------------------------------
module rhps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [rhps_pkg::CMD_BITS-1:0]   in_command,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rhps_pkg::OUT_BITS-1:0]   out_bin_count,
  input logic [rhps_pkg::OUT_BITS-1:0]   out_peak_count,
  input logic [rhps_pkg::BAR_BITS-1:0]   out_bar_height
);

  // The clearing pass after reset keeps the command channel closed.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command channel open right after reset");

  // A clear transfer is followed by the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == rhps_pkg::CMD_CLEAR))
      |=> !in_ready ##1 !in_ready)
    else $error("command taken during clearing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_bin_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bin_count <= out_peak_count))
    else $error("bin count above channel peak");

  a_zero_peak_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_peak_count == '0)) |-> (out_bar_height == '0))
    else $error("nonzero bar height with zero peak");

endmodule

bind rgb_histogram_peak_scaler rhps_checker u_rhps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_command     (in_chan.command),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_bin_count  (out_chan.bin_count),
  .out_peak_count (out_chan.peak_count),
  .out_bar_height (out_chan.bar_height)
);

[tb/sv/tb_rgb_histogram_peak_scaler.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Testbench for the RGB histogram peak scaler
// A short table of pixel, query and clear commands, then random phases under
// several register settings. Every query result is compared against a pinned
// value or a histogram kept here, with random stalls and a long output hold-off.
// -----------------------------------------------------------------------------
module tb_rgb_histogram_peak_scaler;
  import rhps_pkg::*;

  localparam logic [CMD_BITS-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [CHAN_BITS-1:0] CH_BLUE    = 2'd0;
  localparam logic [CHAN_BITS-1:0] CH_GREEN   = 2'd1;
  localparam logic [CHAN_BITS-1:0] CH_RED     = 2'd2;
  localparam logic [CHAN_BITS-1:0] CH_NONE    = 2'd3;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 260;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 160;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_CAP     = 50;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    sample_t              blue;
    sample_t              green;
    sample_t              red;
    logic [CHAN_BITS-1:0] chan;
    bin_t                 qbin;
  } hist_cmd_t;

  typedef struct packed {
    out_t bin_count;
    out_t peak_count;
    bar_t bar_height;
  } bar_report_t;

  typedef struct packed {
    logic        is_cfg;
    logic        single;
    bar_t        scale;
    hist_cmd_t   cmd;
    logic        pinned;
    bar_report_t gold;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  rhps_in_if  in_chan ();
  rhps_out_if out_chan ();

  rgb_histogram_peak_scaler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Histogram state and register copies as the block should hold them.
  count_t hist_bins [CHANNEL_NUMBER][BIN_NUMBER] = '{default: '0};
  count_t hist_peaks [CHANNEL_NUMBER] = '{default: '0};
  logic   gray_mode = 1'b0;
  bar_t   bar_scale_reg = SCALE_RESET;

  bar_report_t pending_reports [$];
  sample_t     hot_samples [8];
  step_row_t   plan [$];

  bit hold_off_req = 1'b0;
  bit calm_tail    = 1'b0;

  int error_count     = 0;
  int reports_checked = 0;
  int pixels_sent     = 0;
  int queries_sent    = 0;
  int clears_sent     = 0;
  int ignored_sent    = 0;
  int settings_used   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(string what, longint unsigned want, longint unsigned got);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  function automatic bin_t bin_index(sample_t s);
    return (int'(s) >= BIN_NUMBER) ? bin_t'(BIN_NUMBER - 1) : bin_t'(s);
  endfunction

  task automatic add_sample(logic [CHAN_BITS-1:0] ch, sample_t s);
    bin_t   b;
    count_t v;
    b = bin_index(s);
    v = hist_bins[ch][b];
    if (v != COUNT_MAX) begin
      v++;
    end
    hist_bins[ch][b] = v;
    if (v > hist_peaks[ch]) begin
      hist_peaks[ch] = v;
    end
  endtask

  task automatic hist_apply(input hist_cmd_t c, output logic has_report,
                            output bar_report_t rep);
    count_t          cnt;
    count_t          pk;
    logic [PROD_BITS-1:0] quot;
    has_report = 1'b0;
    rep = '0;
    case (c.command)
      CMD_COUNT: begin
        add_sample(CH_BLUE, c.blue);
        if (!gray_mode) begin
          add_sample(CH_GREEN, c.green);
          add_sample(CH_RED, c.red);
        end
      end
      CMD_CLEAR: begin
        foreach (hist_bins[i, j]) hist_bins[i][j] = '0;
        foreach (hist_peaks[i]) hist_peaks[i] = '0;
      end
      CMD_QUERY: begin
        has_report = 1'b1;
        if (c.chan < CHANNEL_NUMBER) begin
          cnt = hist_bins[c.chan][bin_index(c.qbin)];
          pk  = hist_peaks[c.chan];
          // Count and output fields have the same width, so nothing clips here.
          rep.bin_count  = cnt;
          rep.peak_count = pk;
          if (pk != '0) begin
            quot = (PROD_BITS'(cnt) * PROD_BITS'(bar_scale_reg)) / PROD_BITS'(pk);
            rep.bar_height = (quot > PROD_BITS'(1023)) ? '1 : bar_t'(quot);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic sample_t hot_or_any();
    if ($urandom_range(0, 9) < 7) begin
      return hot_samples[$urandom_range(0, 7)];
    end
    return sample_t'($urandom_range(0, 255));
  endfunction

  function automatic hist_cmd_t random_cmd();
    hist_cmd_t c;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      c.command = CMD_UNUSED;
    end else if (roll < 4) begin
      c.command = CMD_CLEAR;
    end else if (roll < 40) begin
      c.command = CMD_QUERY;
    end else begin
      c.command = CMD_COUNT;
    end
    c.blue  = hot_or_any();
    c.green = hot_or_any();
    c.red   = hot_or_any();
    c.qbin  = hot_or_any();
    c.chan  = ($urandom_range(0, 19) == 0) ? CH_NONE : CHAN_BITS'($urandom_range(0, 2));
    return c;
  endfunction

  function automatic step_row_t row_cmd(logic [CMD_BITS-1:0] op, sample_t b, sample_t g,
                                        sample_t r, logic [CHAN_BITS-1:0] ch, bin_t qb);
    step_row_t row;
    row = '0;
    row.cmd = '{command: op, blue: b, green: g, red: r, chan: ch, qbin: qb};
    return row;
  endfunction

  function automatic step_row_t row_pin(logic [CHAN_BITS-1:0] ch, bin_t qb, out_t cnt,
                                        out_t pk, bar_t bar);
    step_row_t row;
    row = row_cmd(CMD_QUERY, '0, '0, '0, ch, qb);
    row.pinned = 1'b1;
    row.gold   = '{bin_count: cnt, peak_count: pk, bar_height: bar};
    return row;
  endfunction

  function automatic step_row_t row_cfg(logic single, bar_t scale);
    step_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.single = single;
    row.scale  = scale;
    return row;
  endfunction

  task automatic issue(hist_cmd_t c, logic pinned, bar_report_t gold);
    logic        produced;
    bar_report_t rep;
    in_chan.valid         <= 1'b1;
    in_chan.command       <= c.command;
    in_chan.sample_blue   <= c.blue;
    in_chan.sample_green  <= c.green;
    in_chan.sample_red    <= c.red;
    in_chan.query_channel <= c.chan;
    in_chan.query_bin     <= c.qbin;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    hist_apply(c, produced, rep);
    if (produced) begin
      pending_reports.push_back(pinned ? gold : rep);
    end
    if (c.command == CMD_COUNT) begin
      pixels_sent++;
    end else if (c.command == CMD_QUERY) begin
      queries_sent++;
    end else if (c.command == CMD_CLEAR) begin
      clears_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  task automatic sender_pause();
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // A clear keeps the block busy for a full RAM pass without any result, so the
  // wait after the last result covers that pass.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic single, bar_t scale);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SINGLE_CHANNEL;
    cfg_wdata <= CFG_DATA_BITS'(single);
    @(posedge clk);
    cfg_index <= CFG_BAR_SCALE;
    cfg_wdata <= CFG_DATA_BITS'(scale);
    @(posedge clk);
    cfg_we <= 1'b0;
    gray_mode     = single;
    bar_scale_reg = scale;
    settings_used++;
  endtask

  always @(posedge clk) begin : result_check
    bar_report_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        report_error("result with nothing outstanding, bin_count", 0, out_chan.bin_count);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_chan.bin_count !== want.bin_count) begin
          report_error("bin_count", want.bin_count, out_chan.bin_count);
        end
        if (out_chan.peak_count !== want.peak_count) begin
          report_error("peak_count", want.peak_count, out_chan.peak_count);
        end
        if (out_chan.bar_height !== want.bar_height) begin
          report_error("bar_height", want.bar_height, out_chan.bar_height);
        end
      end
    end
  end

  initial begin : result_sink
    int run;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        run = $urandom_range(1, 24);
        while (run > 0 && !hold_off_req) begin
          @(posedge clk);
          run--;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("tb_rgb_histogram_peak_scaler: done, errors");
    $finish;
  end

  initial begin : stimulus
    hist_cmd_t c;
    int        done;
    logic      single;
    bar_t      scale;

    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_chan.valid         <= 1'b0;
    in_chan.command       <= '0;
    in_chan.sample_blue   <= '0;
    in_chan.sample_green  <= '0;
    in_chan.sample_red    <= '0;
    in_chan.query_channel <= '0;
    in_chan.query_bin     <= '0;

    // Empty histograms, channel beyond the last, ignored command, then a few
    // pixels, a clear, a mode change that keeps old counts and a zero scale.
    plan.push_back(row_pin(CH_BLUE, 8'h00, 0, 0, 0));
    plan.push_back(row_pin(CH_RED, 8'hFF, 0, 0, 0));
    plan.push_back(row_pin(CH_NONE, 8'h00, 0, 0, 0));
    plan.push_back(row_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, CH_NONE, 8'hFF));
    plan.push_back(row_cmd(CMD_COUNT, 8'h00, 8'hFF, 8'h80, CH_NONE, 8'hFF));
    plan.push_back(row_cmd(CMD_COUNT, 8'h00, 8'hFF, 8'h7F, CH_BLUE, 8'h00));
    plan.push_back(row_cmd(CMD_COUNT, 8'h00, 8'h00, 8'h80, CH_RED, 8'h55));
    plan.push_back(row_pin(CH_BLUE, 8'h00, 3, 3, 125));
    plan.push_back(row_pin(CH_GREEN, 8'hFF, 2, 2, 125));
    plan.push_back(row_cmd(CMD_QUERY, 8'h00, 8'h00, 8'h00, CH_GREEN, 8'h00));
    plan.push_back(row_pin(CH_RED, 8'h80, 2, 2, 125));
    plan.push_back(row_cmd(CMD_QUERY, 8'h00, 8'h00, 8'h00, CH_RED, 8'h7F));
    plan.push_back(row_pin(CH_NONE, 8'hFF, 0, 0, 0));
    plan.push_back(row_cmd(CMD_CLEAR, 8'hAA, 8'h55, 8'hAA, CH_GREEN, 8'hAA));
    plan.push_back(row_pin(CH_BLUE, 8'h00, 0, 0, 0));
    plan.push_back(row_cmd(CMD_COUNT, 8'h55, 8'hAA, 8'h01, CH_BLUE, 8'h00));
    plan.push_back(row_cfg(1'b1, 10'd1023));
    plan.push_back(row_cmd(CMD_COUNT, 8'h55, 8'h12, 8'h34, CH_BLUE, 8'h00));
    plan.push_back(row_cmd(CMD_COUNT, 8'hFF, 8'hAA, 8'hAA, CH_BLUE, 8'h00));
    plan.push_back(row_pin(CH_BLUE, 8'h55, 2, 2, 1023));
    plan.push_back(row_cmd(CMD_QUERY, 8'h00, 8'h00, 8'h00, CH_BLUE, 8'hFF));
    plan.push_back(row_pin(CH_GREEN, 8'hAA, 1, 1, 1023));
    plan.push_back(row_cfg(1'b0, 10'd0));
    plan.push_back(row_pin(CH_BLUE, 8'h55, 2, 2, 0));
    plan.push_back(row_cfg(1'b0, 10'd1));
    plan.push_back(row_cmd(CMD_QUERY, 8'h00, 8'h00, 8'h00, CH_RED, 8'h01));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle();
        write_regs(plan[k].single, plan[k].scale);
      end else begin
        issue(plan[k].cmd, plan[k].pinned, plan[k].gold);
        sender_pause();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      single = (ph == 1 || ph == 3);
      case (ph)
        0:       scale = 10'd1023;
        1:       scale = 10'd1;
        5:       scale = SCALE_RESET;
        default: scale = bar_t'($urandom_range(2, 1022));
      endcase
      write_regs(single, scale);
      foreach (hot_samples[i]) hot_samples[i] = sample_t'($urandom_range(0, 255));
      calm_tail = (ph == PHASES - 1);

      // Hold the result side off while queries and pixels keep coming, so a
      // result backs up and the next query stalls the input.
      if (ph == 2) begin
        hold_off_req = 1'b1;
        repeat (10) begin
          c = random_cmd();
          c.command = CMD_QUERY;
          issue(c, 1'b0, '0);
          repeat (6) begin
            c = random_cmd();
            c.command = CMD_COUNT;
            issue(c, 1'b0, '0);
          end
        end
      end

      done = 0;
      while (done < PHASE_ITEMS) begin
        c = random_cmd();
        issue(c, 1'b0, '0);
        if (c.command != CMD_UNUSED) begin
          done++;
        end
        sender_pause();
      end
    end

    settle();
    $display("covered %0d pixels, %0d queries, %0d clears, %0d ignored commands",
             pixels_sent, queries_sent, clears_sent, ignored_sent);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             settings_used, reports_checked, error_count);
    if (error_count == 0) begin
      $display("tb_rgb_histogram_peak_scaler: done, clean");
    end else begin
      $display("tb_rgb_histogram_peak_scaler: done, errors");
    end
    $finish;
  end

endmodule
